[rtl/core/bmp24_stream_to_argb_assert.svh]
// Assertion macros for the BMP decoder RTL, included by the parser (bmp24_front).
`ifndef BMP24_STREAM_TO_ARGB_ASSERT_SVH
`define BMP24_STREAM_TO_ARGB_ASSERT_SVH

// Same-cycle implication, reset masked.
`define BMP24_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define BMP24_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bmp24_pkg.sv]
// Shared types and constants for the 24-bit BMP stream decoder.
package bmp24_pkg;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_DONE
    } phase_t;

    typedef enum logic {
        KIND_PIXEL,
        KIND_ERROR
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MAGIC,
        ERR_FORMAT,
        ERR_SIZE,
        ERR_OFFSET
    } err_code_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] argb;
        logic [11:0] column;
        logic [11:0] row;
        logic        last;
        err_code_t   code;
    } result_t;

    localparam logic [15:0] BMP_MAGIC      = 16'h4D42;
    localparam logic [15:0] BMP_BPP24      = 16'd24;
    localparam logic [31:0] HEADER_END     = 32'd54;
    localparam logic [31:0] LAST_HDR_BYTE  = 32'd33;
    localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
    localparam logic [31:0] POS_SATURATED  = 32'hFFFF_FFFF;
    localparam int          QUEUE_DEPTH    = 2;

endpackage

[rtl/core/bmp24_stream_to_argb.sv]
// Top level of the streaming 24-bit BMP to ARGB decoder.
// Input channel: one file byte per item (file_byte, start_of_file) under
// item_valid/item_ready. start_of_file marks byte 0 of a new file.
// Result channel: result_valid/result_ready carries either a pixel
// (result_kind 0: argb_pixel, pixel_column, flipped pixel_row, last_pixel)
// or a header error (result_kind 1: error_code).
// Throughput: one byte per cycle while the result queue is not full; the
// parser updates all of its counters and header fields in the cycle a
// byte is taken. Path: parser -> two-entry queue -> output register; a
// result is written to the queue at the edge that accepts its byte.
// Stall: when the receiver holds result_ready low, the queue absorbs up to
// two results, then item_ready drops until the output register drains.
// Reset: the parser returns to the header phase and the next byte counts
// as file byte 0; queue and output are emptied. Bytes after an error or
// the last pixel are taken and dropped until the next start_of_file.
module bmp24_stream_to_argb
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  file_byte,
    input  logic        start_of_file,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        result_kind,
    output logic [31:0] argb_pixel,
    output logic [11:0] pixel_column,
    output logic [11:0] pixel_row,
    output logic        last_pixel,
    output logic [1:0]  error_code
);

    logic    push;
    result_t push_data;
    logic    q_full;
    logic    pop;
    result_t head;
    logic    q_not_empty;

    assign item_ready = !q_full;

    bmp24_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .file_byte     (file_byte),
        .start_of_file (start_of_file),
        .push          (push),
        .push_data     (push_data)
    );

    bmp24_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (head),
        .not_empty (q_not_empty)
    );

    bmp24_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (q_not_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_kind  (result_kind),
        .argb_pixel   (argb_pixel),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .last_pixel   (last_pixel),
        .error_code   (error_code)
    );

endmodule

[rtl/core/bmp24_front.sv]
// Byte parser: header capture and checks, skip to data, pixel assembly.
module bmp24_front
    import bmp24_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [7:0]  file_byte,
    input  logic        start_of_file,
    output logic        push,
    output result_t     push_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    phase_t          phase_reg, phase_next;
    logic [31:0]     pos_reg, pos_next;
    logic [15:0]     magic_reg, magic_next;
    logic [31:0]     dstart_reg, dstart_next;
    logic [31:0]     width_reg, width_next;
    logic [31:0]     height_reg, height_next;
    logic [15:0]     bpp_reg, bpp_next;
    logic [31:0]     comp_reg, comp_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [1:0]      bip_reg, bip_next;
    logic [1:0]      pad_reg, pad_next;
    logic [15:0]     bg_reg, bg_next;

    // values after an optional restart, before this byte is applied
    phase_t          b_phase;
    logic [31:0]     b_pos;
    logic            accept;
    logic            emit;
    logic            do_pixel;
    logic            last_col;
    logic            last_row;
    result_t         tok;

    assign accept = item_valid && item_ready;

    always_comb
    begin
        b_phase     = start_of_file ? PH_HEADER : phase_reg;
        b_pos       = start_of_file ? 32'd0 : pos_reg;
        phase_next  = b_phase;
        pos_next    = (b_pos == POS_SATURATED) ? b_pos : b_pos + 32'd1;
        magic_next  = start_of_file ? 16'd0 : magic_reg;
        dstart_next = start_of_file ? 32'd0 : dstart_reg;
        width_next  = start_of_file ? 32'd0 : width_reg;
        height_next = start_of_file ? 32'd0 : height_reg;
        bpp_next    = start_of_file ? 16'd0 : bpp_reg;
        comp_next   = start_of_file ? 32'd0 : comp_reg;
        col_next    = start_of_file ? '0 : col_reg;
        row_next    = start_of_file ? '0 : row_reg;
        bip_next    = start_of_file ? 2'd0 : bip_reg;
        pad_next    = start_of_file ? 2'd0 : pad_reg;
        bg_next     = start_of_file ? 16'd0 : bg_reg;
        emit        = 1'b0;
        do_pixel    = 1'b0;
        last_col    = 1'b0;
        last_row    = 1'b0;
        tok.kind    = KIND_PIXEL;
        tok.argb    = 32'd0;
        tok.column  = 12'd0;
        tok.row     = 12'd0;
        tok.last    = 1'b0;
        tok.code    = ERR_MAGIC;

        unique case (b_phase)
            PH_HEADER:
            begin
                if (b_pos[31:6] == 26'd0)
                begin
                    unique case (b_pos[5:0])
                        6'd0:  magic_next[7:0]    = file_byte;
                        6'd1:  magic_next[15:8]   = file_byte;
                        6'd10: dstart_next[7:0]   = file_byte;
                        6'd11: dstart_next[15:8]  = file_byte;
                        6'd12: dstart_next[23:16] = file_byte;
                        6'd13: dstart_next[31:24] = file_byte;
                        6'd18: width_next[7:0]    = file_byte;
                        6'd19: width_next[15:8]   = file_byte;
                        6'd20: width_next[23:16]  = file_byte;
                        6'd21: width_next[31:24]  = file_byte;
                        6'd22: height_next[7:0]   = file_byte;
                        6'd23: height_next[15:8]  = file_byte;
                        6'd24: height_next[23:16] = file_byte;
                        6'd25: height_next[31:24] = file_byte;
                        6'd28: bpp_next[7:0]      = file_byte;
                        6'd29: bpp_next[15:8]     = file_byte;
                        6'd30: comp_next[7:0]     = file_byte;
                        6'd31: comp_next[15:8]    = file_byte;
                        6'd32: comp_next[23:16]   = file_byte;
                        6'd33: comp_next[31:24]   = file_byte;
                        default: ;
                    endcase
                end
                if (b_pos == LAST_HDR_BYTE)
                begin
                    // first fault wins: magic, format, size, offset
                    tok.kind = KIND_ERROR;
                    emit     = 1'b1;
                    phase_next = PH_DONE;
                    priority if (magic_next != BMP_MAGIC)
                        tok.code = ERR_MAGIC;
                    else if (bpp_next != BMP_BPP24 || comp_next != 32'd0)
                        tok.code = ERR_FORMAT;
                    else if (width_next > 32'(MAX_WIDTH) || height_next > 32'(MAX_HEIGHT))
                        tok.code = ERR_SIZE;
                    else if (dstart_next < HEADER_END)
                        tok.code = ERR_OFFSET;
                    else
                    begin
                        emit = 1'b0;
                        tok.kind = KIND_PIXEL;
                        if (width_next != 32'd0 && height_next != 32'd0)
                            phase_next = PH_SKIP;
                    end
                end
            end
            PH_SKIP:
            begin
                if (b_pos == dstart_reg)
                begin
                    do_pixel   = 1'b1;
                    phase_next = PH_PIXEL;
                end
            end
            PH_PIXEL: do_pixel = 1'b1;
            PH_DONE:  ;
            default:  ;
        endcase

        if (do_pixel)
        begin
            priority if (pad_next != 2'd0)
                pad_next = pad_next - 2'd1;
            else if (bip_next == 2'd0)
            begin
                bg_next  = {8'd0, file_byte};
                bip_next = 2'd1;
            end
            else if (bip_next == 2'd1)
            begin
                bg_next[15:8] = file_byte;
                bip_next      = 2'd2;
            end
            else
            begin
                bip_next   = 2'd0;
                last_col   = (col_next == CW'(width_reg - 32'd1));
                last_row   = (row_next == RW'(height_reg - 32'd1));
                emit       = 1'b1;
                tok.argb   = {ALPHA_OPAQUE, file_byte, bg_next};
                tok.column = 12'(col_next);
                tok.row    = 12'(height_reg) - 12'd1 - 12'(row_next);
                tok.last   = last_col && last_row;
                priority if (last_col && last_row)
                    phase_next = PH_DONE;
                else if (last_col)
                begin
                    col_next = '0;
                    row_next = row_next + RW'(1);
                    // row pad to 4 bytes equals width mod 4 for 3-byte pixels
                    pad_next = width_reg[1:0];
                end
                else
                    col_next = col_next + CW'(1);
            end
        end
    end

    assign push      = accept && emit;
    assign push_data = tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= 32'd0;
            magic_reg  <= 16'd0;
            dstart_reg <= 32'd0;
            width_reg  <= 32'd0;
            height_reg <= 32'd0;
            bpp_reg    <= 16'd0;
            comp_reg   <= 32'd0;
            col_reg    <= '0;
            row_reg    <= '0;
            bip_reg    <= 2'd0;
            pad_reg    <= 2'd0;
            bg_reg     <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            magic_reg  <= magic_next;
            dstart_reg <= dstart_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            comp_reg   <= comp_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            pad_reg    <= pad_next;
            bg_reg     <= bg_next;
        end
    end

`include "bmp24_stream_to_argb_assert.svh"

    `BMP24_ASSERT_NOW(a_err_only_at_check,
        push && push_data.kind == KIND_ERROR,
        b_phase == PH_HEADER && b_pos == LAST_HDR_BYTE,
        "error item outside the header check byte")

    `BMP24_ASSERT_NEXT(a_last_ends_image,
        push && push_data.kind == KIND_PIXEL && push_data.last,
        phase_reg == PH_DONE,
        "parser still active after last pixel")

    `BMP24_ASSERT_NOW(a_pad_between_pixels,
        pad_reg != 2'd0,
        bip_reg == 2'd0,
        "row padding pending inside a pixel")

endmodule

[rtl/core/bmp24_queue.sv]
// Two-entry result queue between the parser and the output stage.
module bmp24_queue
    import bmp24_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output result_t pop_data,
    output logic    not_empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    result_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;

    assign full      = (count_reg == NW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/bmp24_back.sv]
// Output stage: registers the head of the queue and drives the result channel.
module bmp24_back
    import bmp24_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        not_empty,
    input  result_t     head,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        result_kind,
    output logic [31:0] argb_pixel,
    output logic [11:0] pixel_column,
    output logic [11:0] pixel_row,
    output logic        last_pixel,
    output logic [1:0]  error_code
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    // load when the output slot is empty or is being taken this cycle
    assign pop        = not_empty && (!valid_reg || result_ready);
    assign valid_next = pop ? 1'b1 : (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head;
    end

    assign result_valid = valid_reg;
    assign result_kind  = data_reg.kind;
    assign argb_pixel   = data_reg.argb;
    assign pixel_column = data_reg.column;
    assign pixel_row    = data_reg.row;
    assign last_pixel   = data_reg.last;
    assign error_code   = data_reg.code;

endmodule

[dv/tb_bmp24_stream_to_argb.sv]
// Self-checking testbench for the streaming 24-bit BMP to ARGB decoder.
`timescale 1ns / 1ps

module tb_bmp24_stream_to_argb;
    import bmp24_pkg::*;

    localparam int unsigned MAX_W       = 4096;
    localparam int unsigned MAX_H       = 4096;
    localparam int          HOLD_CYCLES = 300;
    localparam int          STALL_LIMIT = 4000;
    localparam int          RANDOM_BYTES = 200;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [7:0]  file_byte;
    logic        start_of_file;
    logic        result_valid;
    logic        result_ready;
    logic        result_kind;
    logic [31:0] argb_pixel;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        last_pixel;
    logic [1:0]  error_code;

    bmp24_stream_to_argb #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .file_byte     (file_byte),
        .start_of_file (start_of_file),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_kind   (result_kind),
        .argb_pixel    (argb_pixel),
        .pixel_column  (pixel_column),
        .pixel_row     (pixel_row),
        .last_pixel    (last_pixel),
        .error_code    (error_code)
    );

    // decoder shadow state
    phase_t      phase;
    logic [31:0] byte_pos;
    logic [15:0] magic;
    logic [31:0] data_start;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] bpp;
    logic [31:0] compr;
    logic [31:0] col_cnt;
    logic [31:0] row_cnt;
    logic [1:0]  bip;
    logic [1:0]  pad_left;
    logic [15:0] held_bg;

    result_t     due_results[$];

    bit          idle_on;
    bit          stall_on;
    bit          hold_req;
    int          mismatches;
    int          pixels_seen;
    int          errors_seen;
    int          files_sent;
    int          bytes_sent;
    int          stall_cnt;
    logic [3:0]  codes_seen;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic clear_decoder();
        phase      = PH_HEADER;
        byte_pos   = '0;
        magic      = '0;
        data_start = '0;
        width      = '0;
        height     = '0;
        bpp        = '0;
        compr      = '0;
        col_cnt    = '0;
        row_cnt    = '0;
        bip        = '0;
        pad_left   = '0;
        held_bg    = '0;
    endtask

    task automatic check_header();
        err_code_t fault;
        bit        bad;
        result_t   r;
        bad   = 1'b1;
        fault = ERR_MAGIC;
        if (magic != BMP_MAGIC)
            fault = ERR_MAGIC;
        else if (bpp != BMP_BPP24 || compr != 0)
            fault = ERR_FORMAT;
        else if (width > MAX_W || height > MAX_H)
            fault = ERR_SIZE;
        else if (data_start < HEADER_END)
            fault = ERR_OFFSET;
        else
            bad = 1'b0;
        if (bad)
        begin
            phase  = PH_DONE;
            r      = '0;
            r.kind = KIND_ERROR;
            r.code = fault;
            due_results.push_back(r);
        end
        else
        begin
            phase = (width == 0 || height == 0) ? PH_DONE : PH_SKIP;
        end
    endtask

    task automatic pixel_byte(input logic [7:0] b);
        logic [31:0] y;
        bit          fin;
        result_t     r;
        if (pad_left != 0)
            pad_left = pad_left - 1'b1;
        else if (bip == 2'd0)
        begin
            held_bg = {8'h00, b};
            bip     = 2'd1;
        end
        else if (bip == 2'd1)
        begin
            held_bg[15:8] = b;
            bip           = 2'd2;
        end
        else
        begin
            bip      = 2'd0;
            y        = height - 1 - row_cnt;
            fin      = (col_cnt == width - 1) && (row_cnt == height - 1);
            r        = '0;
            r.kind   = KIND_PIXEL;
            r.argb   = {ALPHA_OPAQUE, b, held_bg};
            r.column = col_cnt[11:0];
            r.row    = y[11:0];
            r.last   = fin;
            r.code   = ERR_MAGIC;
            due_results.push_back(r);
            if (fin)
                phase = PH_DONE;
            else if (col_cnt == width - 1)
            begin
                col_cnt  = '0;
                row_cnt  = row_cnt + 1;
                // rows are padded to a multiple of four bytes
                pad_left = 2'(0 - width * 3);
            end
            else
                col_cnt = col_cnt + 1;
        end
    endtask

    // Advance the shadow decoder by one accepted byte.
    task automatic decode_byte(input logic [7:0] b, input logic sof);
        logic [31:0] p;
        logic [1:0]  k;
        if (sof)
            clear_decoder();
        p = byte_pos;
        if (byte_pos != POS_SATURATED)
            byte_pos = byte_pos + 1;
        if (phase == PH_HEADER)
        begin
            if (p < 2)
                magic[{p[0], 3'b000} +: 8] = b;
            else if (p >= 10 && p <= 13)
            begin
                k = 2'(p - 10);
                data_start[{k, 3'b000} +: 8] = b;
            end
            else if (p >= 18 && p <= 21)
            begin
                k = 2'(p - 18);
                width[{k, 3'b000} +: 8] = b;
            end
            else if (p >= 22 && p <= 25)
            begin
                k = 2'(p - 22);
                height[{k, 3'b000} +: 8] = b;
            end
            else if (p >= 28 && p <= 29)
                bpp[{p[0], 3'b000} +: 8] = b;
            else if (p >= 30 && p <= 33)
            begin
                k = 2'(p - 30);
                compr[{k, 3'b000} +: 8] = b;
            end
            if (p == LAST_HDR_BYTE)
                check_header();
        end
        else
        begin
            if (phase == PH_SKIP && p == data_start)
                phase = PH_PIXEL;
            if (phase == PH_PIXEL)
                pixel_byte(b);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input logic sof);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        item_valid    = 1'b1;
        file_byte     = b;
        start_of_file = sof;
        do
            @(posedge clk);
        while (!item_ready);
        decode_byte(b, sof);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Sends one file; cut < 0 sends it whole, tail adds bytes after it.
    task automatic send_bmp(input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] off, input logic [15:0] mg,
                            input logic [15:0] bits, input logic [31:0] comp,
                            input bit sof, input int cut, input int tail);
        logic [7:0]  hdr [54];
        int unsigned n;
        int unsigned i;
        foreach (hdr[j])
            hdr[j] = 8'($urandom);
        {hdr[1], hdr[0]}                     = mg;
        {hdr[13], hdr[12], hdr[11], hdr[10]} = off;
        {hdr[21], hdr[20], hdr[19], hdr[18]} = w;
        {hdr[25], hdr[24], hdr[23], hdr[22]} = h;
        {hdr[29], hdr[28]}                   = bits;
        {hdr[33], hdr[32], hdr[31], hdr[30]} = comp;
        n = LAST_HDR_BYTE + 1;
        if (mg == BMP_MAGIC && bits == BMP_BPP24 && comp == 0 &&
            w <= MAX_W && h <= MAX_H && off >= HEADER_END)
            n = off + (w * 3 + 32'(2'(0 - w * 3))) * h;
        if (cut >= 0 && cut < n)
            n = cut;
        for (i = 0; i < n; i++)
            send_byte((i < 54) ? hdr[i] : 8'($urandom), sof && i == 0);
        repeat (tail) send_byte(8'($urandom), 1'b0);
        files_sent++;
    endtask

    task automatic send_good(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] off);
        send_bmp(w, h, off, BMP_MAGIC, BMP_BPP24, 32'd0, 1'b1, -1, 0);
    endtask

    task automatic test_reset_as_start();
        send_bmp(2, 2, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b0, -1, 0);
    endtask

    task automatic test_header_faults();
        send_bmp(2, 2, 54, 16'h4D43, BMP_BPP24, 0, 1'b1, -1, 3);
        send_bmp(2, 2, 54, 16'h4242, BMP_BPP24, 0, 1'b1, -1, 3);
        send_bmp(2, 2, 54, 16'h424D, BMP_BPP24, 0, 1'b1, -1, 0);
        send_bmp(2, 2, 54, BMP_MAGIC, 16'd32, 0, 1'b1, -1, 0);
        send_bmp(2, 2, 54, BMP_MAGIC, 16'h0118, 0, 1'b1, -1, 0);
        send_bmp(2, 2, 54, BMP_MAGIC, BMP_BPP24, 32'd1, 1'b1, -1, 0);
        send_bmp(2, 2, 54, BMP_MAGIC, BMP_BPP24, 32'h8000_0000, 1'b1, -1, 0);
        send_bmp(MAX_W + 1, 2, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 0);
        send_bmp(2, 32'hFFFF_FFFF, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 0);
        send_bmp(32'h0001_0000, 2, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 0);
        send_bmp(2, 2, 53, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 4);
        send_bmp(2, 2, 0, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 0);
        // several faults at once: only the first in priority order counts
        send_bmp(2, 2, 54, 16'h0000, 16'd8, 0, 1'b1, -1, 0);
        send_bmp(9999, 2, 54, BMP_MAGIC, 16'd8, 0, 1'b1, -1, 0);
        send_bmp(9999, 2, 10, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 0);
    endtask

    task automatic test_empty_images();
        send_bmp(0, 3, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 4);
        send_bmp(3, 0, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 4);
    endtask

    task automatic test_row_padding();
        int w;
        for (w = 1; w <= 4; w++)
            send_good(w, 2, 54 + $urandom_range(0, 6));
    endtask

    task automatic test_size_limits();
        // largest legal sizes, each cut after a few pixels
        send_bmp(MAX_W, 1, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, 54 + 3 * 8, 0);
        send_bmp(1, MAX_H, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, 54 + 4 * 8, 0);
        send_bmp(MAX_W, MAX_H, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, 54 + 3 * 8, 0);
    endtask

    task automatic test_restart_and_trailing();
        send_bmp(3, 3, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, 20, 0);
        send_bmp(3, 3, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, 33, 0);
        send_bmp(3, 3, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, 54 + 7, 0);
        send_bmp(2, 2, 54, BMP_MAGIC, BMP_BPP24, 0, 1'b1, -1, 10);
        send_good(2, 2, 100);
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        send_good(8, 4, 54);
    endtask

    task automatic test_random_files();
        int          start_bytes;
        int          pick;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] off;
        logic [15:0] mg;
        logic [15:0] bits;
        logic [31:0] comp;
        int          cut;
        int          tail;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            w    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
            h    = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            off  = ($urandom_range(0, 7) == 0) ? 54 + $urandom_range(0, 40)
                                               : 54 + $urandom_range(0, 8);
            mg   = BMP_MAGIC;
            bits = BMP_BPP24;
            comp = 0;
            cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(34, 120) : -1;
            tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (pick < 70)
                send_bmp(w, h, off, mg, bits, comp, 1'b1, cut, tail);
            else if (pick < 85)
            begin
                case ($urandom_range(0, 4))
                    0: mg = 16'($urandom);
                    1: bits = ($urandom_range(0, 1) == 0) ? 16'd32 : 16'($urandom);
                    2: comp = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : $urandom;
                    3: if ($urandom_range(0, 1) == 0)
                           w = MAX_W + 1 + $urandom_range(0, 100);
                       else
                           h = $urandom | 32'h8000_0000;
                    default: off = $urandom_range(0, 53);
                endcase
                if ($urandom_range(0, 3) == 0)
                    off = $urandom_range(0, 53);
                send_bmp(w, h, off, mg, bits, comp, 1'b1, -1, tail);
            end
            else if (pick < 95)
                send_bmp(w, h, off, mg, bits, comp, 1'b1, $urandom_range(1, 33), 0);
            else
                repeat ($urandom_range(10, 30))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic test_steady_stream();
        idle_on  = 1'b0;
        stall_on = 1'b0;
        send_good(5, 3, 54);
        send_bmp(4, 2, 54, BMP_MAGIC, 16'd16, 0, 1'b1, -1, 0);
        send_good(3, 2, 57);
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual kind %0d argb %h",
                         $time, result_kind, argb_pixel);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (result_kind !== want.kind)
                    note_mismatch("result_kind", want.kind, result_kind);
                if (argb_pixel !== want.argb)
                    note_mismatch("argb_pixel", want.argb, argb_pixel);
                if (pixel_column !== want.column)
                    note_mismatch("pixel_column", want.column, pixel_column);
                if (pixel_row !== want.row)
                    note_mismatch("pixel_row", want.row, pixel_row);
                if (last_pixel !== want.last)
                    note_mismatch("last_pixel", want.last, last_pixel);
                if (error_code !== want.code)
                    note_mismatch("error_code", want.code, error_code);
                if (want.kind == KIND_ERROR)
                begin
                    errors_seen++;
                    codes_seen[want.code] = 1'b1;
                end
                else
                    pixels_seen++;
            end
        end
    end

    // watchdog: cycles in a row with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, due_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result receiver
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req     = 1'b0;
                result_ready = 1'b1;
            end
            else if (stall_on && $urandom_range(0, 7) == 0)
            begin
                result_ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                result_ready = 1'b1;
            end
            else
                result_ready = 1'b1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        file_byte     = 8'h00;
        start_of_file = 1'b0;
        idle_on       = 1'b1;
        stall_on      = 1'b1;
        hold_req      = 1'b0;
        mismatches    = 0;
        pixels_seen   = 0;
        errors_seen   = 0;
        files_sent    = 0;
        bytes_sent    = 0;
        stall_cnt     = 0;
        codes_seen    = '0;
        clear_decoder();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_as_start();
        test_header_faults();
        test_empty_images();
        test_row_padding();
        test_size_limits();
        test_restart_and_trailing();
        test_output_backpressure();
        test_random_files();
        test_steady_stream();

        item_valid    = 1'b0;
        start_of_file = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Decoded %0d files from %0d bytes: %0d pixels, %0d header errors",
                 files_sent, bytes_sent, pixels_seen, errors_seen);
        $display("Error codes seen (bit per code): %b, mismatches: %0d",
                 codes_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
